// ----- sv/video_plane_layout_calc_top_assert.svh -----
// ----------------------------------------------------------------------------
// Layout calculator assertion macros
// Implication and next-cycle checks clocked on the rising edge and gated by reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_PLANE_LAYOUT_CALC_TOP_ASSERT_SVH
`define VIDEO_PLANE_LAYOUT_CALC_TOP_ASSERT_SVH

// same-cycle implication
`define VPLC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vplc: same-cycle check failed");

// next-cycle implication
`define VPLC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vplc: next-cycle check failed");

`endif

// ----- sv/vplc_pkg.sv -----
// ----------------------------------------------------------------------------
// vplc_pkg
// Format codes, field widths and defaults for the plane layout calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vplc_pkg;

   localparam int FORMAT_W    = 5;
   localparam int DIM_W       = 14;
   localparam int SIZE_W      = 31;
   localparam int PITCH_W     = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 192;

   localparam int DEF_ALIGN_BYTES = 32;
   localparam int DEF_DIM_BITS    = 14;

   typedef logic [FORMAT_W-1:0] format_type;
   typedef logic [2:0]          plane_cnt_type;

   localparam format_type FMT_NONE = 5'd0;
   localparam format_type FMT_I420 = 5'd1;
   localparam format_type FMT_NV12 = 5'd2;
   localparam format_type FMT_Y800 = 5'd3;
   localparam format_type FMT_YVYU = 5'd4;
   localparam format_type FMT_YUY2 = 5'd5;
   localparam format_type FMT_UYVY = 5'd6;
   localparam format_type FMT_RGBA = 5'd7;
   localparam format_type FMT_BGRA = 5'd8;
   localparam format_type FMT_BGRX = 5'd9;
   localparam format_type FMT_AYUV = 5'd10;
   localparam format_type FMT_I444 = 5'd11;
   localparam format_type FMT_BGR3 = 5'd12;
   localparam format_type FMT_I422 = 5'd13;
   localparam format_type FMT_I40A = 5'd14;
   localparam format_type FMT_I42A = 5'd15;
   localparam format_type FMT_YUVA = 5'd16;

endpackage

// ----- sv/video_plane_layout_calc_top.sv -----
// ----------------------------------------------------------------------------
// video_plane_layout_calc_top
// Frame buffer layout (total size, plane offsets, line pitches) per format.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while req_tready is high and returns one
// response word per request, in order. The three register stages are: the
// plane products w*h, w/2*h/2 and w/2*h; the aligned quotient of each plane
// size (a shift for a power-of-two ALIGN_BYTES, else a constant reciprocal
// multiply); and the response register, where the quotients are scaled back
// and summed into offsets.
// Stages hold their word under back-pressure and bubbles are squeezed out,
// so a request is taken while a finished response waits if an earlier stage
// is free. Codes 0 and above 16 give an all-zero response.
`timescale 1ns / 1ps
`include "video_plane_layout_calc_top_assert.svh"

module video_plane_layout_calc_top
   import vplc_pkg::*;
#(
   parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
   parameter int DIM_BITS    = DEF_DIM_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // format_code[4:0], frame_width[18:5], frame_height[32:19], zero[39:33]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // total_bytes[30:0], plane1_offset[61:31], plane2_offset[92:62],
   // plane3_offset[123:93], pitch0[139:124], pitch1[155:140],
   // pitch2[171:156], pitch3[187:172], zero[191:188]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int EB     = (DIM_BITS < DIM_W) ? DIM_BITS : DIM_W;
   localparam int SZW    = 2 * EB + 2;
   localparam int AW1    = $clog2(ALIGN_BYTES + 1);
   localparam int YW     = ((SZW > AW1) ? SZW : AW1) + 1;
   localparam int SUMW   = YW + 2;
   localparam int PW     = EB + 2;
   localparam int L2A    = $clog2(ALIGN_BYTES);
   localparam int RSH    = YW + L2A;
   localparam int PRODW  = 2 * YW + 2;
   localparam bit ALIGN_POW2 = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);
   localparam logic [63:0] RECIP =
      ((64'd1 << RSH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
   localparam logic [YW-1:0] A_Y   = YW'(ALIGN_BYTES);
   localparam logic [YW-1:0] A_M1  = YW'(ALIGN_BYTES - 1);

   // ---------------- flow control ----------------
   logic st1_valid_ff, st1_valid_in;
   logic st2_valid_ff, st2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_en, st2_en, st1_en;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign st2_en     = !st2_valid_ff || out_en;
   assign st1_en     = !st1_valid_ff || st2_en;
   assign req_tready = st1_en;

   assign st1_valid_in = st1_en ? req_tvalid   : st1_valid_ff;
   assign st2_valid_in = st2_en ? st1_valid_ff : st2_valid_ff;
   assign rsp_valid_in = out_en ? st2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= st1_valid_in;
         st2_valid_ff <= st2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- stage 1: products ----------------
   logic [EB-1:0]     req_w, req_h;
   logic [EB-2:0]     req_w2, req_h2;
   format_type        fmt1_ff, fmt1_in;
   logic [EB-1:0]     w1_ff, w1_in;
   logic [2*EB-1:0]   pwh1_ff, pwh1_in;
   logic [2*EB-3:0]   phh1_ff, phh1_in;
   logic [2*EB-2:0]   p2h1_ff, p2h1_in;

   assign req_w  = req_tdata[FORMAT_W +: EB];
   assign req_h  = req_tdata[FORMAT_W + DIM_W +: EB];
   assign req_w2 = req_w[EB-1:1];
   assign req_h2 = req_h[EB-1:1];

   assign fmt1_in = req_tdata[FORMAT_W-1:0];
   assign w1_in   = req_w;
   assign pwh1_in = (2*EB)'(req_w) * (2*EB)'(req_h);
   assign phh1_in = (2*EB-2)'(req_w2) * (2*EB-2)'(req_h2);
   assign p2h1_in = (2*EB-1)'(req_w2) * (2*EB-1)'(req_h);

   always_ff @(posedge clock) begin
      if (st1_en) begin
         fmt1_ff <= fmt1_in;
         w1_ff   <= w1_in;
         pwh1_ff <= pwh1_in;
         phh1_ff <= phh1_in;
         p2h1_ff <= p2h1_in;
      end
   end

   // ---------------- stage 2: sizes and aligned quotients ----------------
   logic [SZW-1:0]  s0, s1, s3;
   logic [SZW-1:0]  wh;
   logic [PW-1:0]   w_x, w2_x;
   plane_cnt_type   planes;
   logic [PW-1:0]   pt0, pt1, pt2, pt3;
   logic [YW-1:0]   y0, y1, y3;
   logic [PRODW-1:0] m0, m1, m3;

   plane_cnt_type   planes2_ff, planes2_in;
   logic [YW-1:0]   q0_ff, q0_in, q1_ff, q1_in, q3_ff, q3_in;
   logic [PW-1:0]   pt0_ff, pt1_ff, pt2_ff, pt3_ff;

   assign wh   = SZW'(pwh1_ff);
   assign w_x  = PW'(w1_ff);
   assign w2_x = PW'(w1_ff[EB-1:1]);

   always_comb begin
      s0     = '0;
      s1     = '0;
      planes = 3'd0;
      pt0    = '0;
      pt1    = '0;
      case (fmt1_ff)
         FMT_I420, FMT_I40A: begin
            planes = (fmt1_ff == FMT_I40A) ? 3'd4 : 3'd3;
            s0 = wh;  s1 = SZW'(phh1_ff);
            pt0 = w_x; pt1 = w2_x;
         end
         FMT_NV12: begin
            planes = 3'd2;
            s0 = wh;  s1 = SZW'(phh1_ff) << 1;
            pt0 = w_x; pt1 = w_x;
         end
         FMT_Y800: begin
            planes = 3'd1;
            s0 = wh;  pt0 = w_x;
         end
         FMT_YVYU, FMT_YUY2, FMT_UYVY: begin
            planes = 3'd1;
            s0 = wh << 1;  pt0 = w_x << 1;
         end
         FMT_RGBA, FMT_BGRA, FMT_BGRX, FMT_AYUV: begin
            planes = 3'd1;
            s0 = wh << 2;  pt0 = w_x << 2;
         end
         FMT_BGR3: begin
            planes = 3'd1;
            s0 = (wh << 1) + wh;  pt0 = (w_x << 1) + w_x;
         end
         FMT_I444, FMT_YUVA: begin
            planes = (fmt1_ff == FMT_YUVA) ? 3'd4 : 3'd3;
            s0 = wh;  s1 = wh;
            pt0 = w_x; pt1 = w_x;
         end
         FMT_I422, FMT_I42A: begin
            planes = (fmt1_ff == FMT_I42A) ? 3'd4 : 3'd3;
            s0 = wh;  s1 = SZW'(p2h1_ff);
            pt0 = w_x; pt1 = w2_x;
         end
         FMT_NONE: begin
            planes = 3'd0;
         end
         default: begin
            planes = 3'd0;
         end
      endcase
      s3  = (planes == 3'd4) ? wh : '0;
      pt2 = (planes >= 3'd3) ? pt1 : '0;
      pt3 = (planes == 3'd4) ? w_x : '0;
   end

   assign y0 = YW'(s0) + A_M1;
   assign y1 = YW'(s1) + A_M1;
   assign y3 = YW'(s3) + A_M1;

   assign m0 = PRODW'(y0) * PRODW'(RECIP);
   assign m1 = PRODW'(y1) * PRODW'(RECIP);
   assign m3 = PRODW'(y3) * PRODW'(RECIP);

   always_comb begin
      if (ALIGN_POW2) begin
         q0_in = y0 >> L2A;
         q1_in = y1 >> L2A;
         q3_in = y3 >> L2A;
      end else begin
         q0_in = YW'(m0 >> RSH);
         q1_in = YW'(m1 >> RSH);
         q3_in = YW'(m3 >> RSH);
      end
   end

   assign planes2_in = planes;

   always_ff @(posedge clock) begin
      if (st2_en) begin
         planes2_ff <= planes2_in;
         q0_ff      <= q0_in;
         q1_ff      <= q1_in;
         q3_ff      <= q3_in;
         pt0_ff     <= pt0;
         pt1_ff     <= pt1;
         pt2_ff     <= pt2;
         pt3_ff     <= pt3;
      end
   end

   // ---------------- stage 3: offsets and totals ----------------
   logic [YW-1:0]   r0, r1, r3;
   logic [SUMW-1:0] off1_s, off2_s, off3_s, total_s;
   logic [SIZE_W-1:0]  total_ff, total_in, off1_ff, off1_in;
   logic [SIZE_W-1:0]  off2_ff, off2_in, off3_ff, off3_in;
   logic [PITCH_W-1:0] pitch0_ff, pitch1_ff, pitch2_ff, pitch3_ff;

   assign r0 = q0_ff * A_Y;
   assign r1 = q1_ff * A_Y;
   assign r3 = q3_ff * A_Y;

   always_comb begin
      off1_s  = SUMW'(r0);
      off2_s  = SUMW'(r0) + SUMW'(r1);
      off3_s  = off2_s + SUMW'(r1);
      total_s = '0;
      case (planes2_ff)
         3'd1:    total_s = off1_s;
         3'd2:    total_s = off2_s;
         3'd3:    total_s = off3_s;
         3'd4:    total_s = off3_s + SUMW'(r3);
         default: total_s = '0;
      endcase
   end

   assign total_in = SIZE_W'(total_s);
   assign off1_in  = (planes2_ff >= 3'd2) ? SIZE_W'(off1_s) : '0;
   assign off2_in  = (planes2_ff >= 3'd3) ? SIZE_W'(off2_s) : '0;
   assign off3_in  = (planes2_ff == 3'd4) ? SIZE_W'(off3_s) : '0;

   always_ff @(posedge clock) begin
      if (out_en) begin
         total_ff  <= total_in;
         off1_ff   <= off1_in;
         off2_ff   <= off2_in;
         off3_ff   <= off3_in;
         pitch0_ff <= PITCH_W'(pt0_ff);
         pitch1_ff <= PITCH_W'(pt1_ff);
         pitch2_ff <= PITCH_W'(pt2_ff);
         pitch3_ff <= PITCH_W'(pt3_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, pitch3_ff, pitch2_ff, pitch1_ff, pitch0_ff,
                        off3_ff, off2_ff, off1_ff, total_ff};

   // ---------------- checks ----------------
   logic offsets_ordered;

   assign offsets_ordered = (off1_ff <= off2_ff) && (off2_ff <= off3_ff) &&
                            (off3_ff <= total_ff);

   `VPLC_ASSERT_IMP(a_ready_when_out_free, clock, reset, !rsp_valid_ff, req_tready)
   `VPLC_ASSERT_NXT(a_st2_moves_to_out, clock, reset, st2_valid_ff && out_en, rsp_valid_ff)
   `VPLC_ASSERT_IMP(a_offsets_ordered, clock, reset, rsp_valid_ff && (off3_ff != '0), offsets_ordered)

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Frame buffer layout calculator testbench
// Drives format/width/height words through the request stream and checks each
// response word against a literal or locally computed layout: a directed table
// first, then random formats and sizes, bursty input, a stalling response side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import vplc_pkg::*;
();

   localparam int ALIGN        = 32;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_WORDS = 750;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;

   typedef logic [DIM_W-1:0] dim_type;

   // lowest bits first: total, off1, off2, off3, pitch0..pitch3, pad
   typedef struct packed {
      logic [3:0]  pad;
      logic [15:0] pitch3, pitch2, pitch1, pitch0;
      logic [30:0] off3, off2, off1, total;
   } layout_type;

   typedef struct {
      format_type fmt;
      dim_type    width;
      dim_type    height;
      bit         literal;
      layout_type want;
   } desc_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   layout_type   layout_q[$];
   desc_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           long_hold_req = 1'b0;

   video_plane_layout_calc_top #(
      .ALIGN_BYTES(ALIGN),
      .DIM_BITS   (DIM_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic layout_type compute_layout(format_type f, dim_type w_in,
                                                 dim_type h_in);
      longint unsigned w, h, w2, h2, run;
      longint unsigned sz[4];
      longint unsigned pt[4];
      longint unsigned off[4];
      int              planes;
      layout_type      r;
      w = 64'(w_in);
      h = 64'(h_in);
      w2 = w / 2;
      h2 = h / 2;
      sz = '{default: 0};
      pt = '{default: 0};
      off = '{default: 0};
      planes = 0;
      case (f)
         FMT_I420, FMT_I40A: begin
            planes = (f == FMT_I40A) ? 4 : 3;
            sz = '{w * h, w2 * h2, w2 * h2, w * h};
            pt = '{w, w2, w2, w};
         end
         FMT_NV12: begin
            planes = 2;
            sz[0] = w * h;
            pt[0] = w;
            sz[1] = w2 * h2 * 2;
            pt[1] = w;
         end
         FMT_Y800: begin
            planes = 1;
            sz[0] = w * h;
            pt[0] = w;
         end
         FMT_YVYU, FMT_YUY2, FMT_UYVY: begin
            planes = 1;
            sz[0] = w * h * 2;
            pt[0] = w * 2;
         end
         FMT_RGBA, FMT_BGRA, FMT_BGRX, FMT_AYUV: begin
            planes = 1;
            sz[0] = w * h * 4;
            pt[0] = w * 4;
         end
         FMT_BGR3: begin
            planes = 1;
            sz[0] = w * h * 3;
            pt[0] = w * 3;
         end
         FMT_I444, FMT_YUVA: begin
            planes = (f == FMT_YUVA) ? 4 : 3;
            sz = '{w * h, w * h, w * h, w * h};
            pt = '{w, w, w, w};
         end
         FMT_I422, FMT_I42A: begin
            planes = (f == FMT_I42A) ? 4 : 3;
            sz = '{w * h, w2 * h, w2 * h, w * h};
            pt = '{w, w2, w2, w};
         end
         default: planes = 0;
      endcase
      run = 0;
      for (int k = 0; k < planes; k++) begin
         off[k] = run;
         run = ((run + sz[k] + ALIGN - 1) / ALIGN) * ALIGN;
      end
      for (int k = planes; k < 4; k++) pt[k] = 0;
      r = '0;
      r.total  = run[30:0];
      r.off1   = off[1][30:0];
      r.off2   = off[2][30:0];
      r.off3   = off[3][30:0];
      r.pitch0 = pt[0][15:0];
      r.pitch1 = pt[1][15:0];
      r.pitch2 = pt[2][15:0];
      r.pitch3 = pt[3][15:0];
      return r;
   endfunction

   function automatic dim_type pick_dim();
      case ($urandom_range(0, 3))
         0:       return dim_type'($urandom_range(0, 40));
         1:       return dim_type'($urandom_range(16300, 16383));
         default: return dim_type'($urandom);
      endcase
   endfunction

   function automatic format_type pick_format();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return format_type'($urandom_range(17, 31));
      if (r < 12) return FMT_NONE;
      return format_type'($urandom_range(1, 16));
   endfunction

   task automatic add_row(format_type f, dim_type w, dim_type h, bit lit,
                          logic [30:0] total, logic [15:0] pitch0);
      desc_row_type row;
      row.fmt = f;
      row.width = w;
      row.height = h;
      row.literal = lit;
      row.want = '0;
      row.want.total = total;
      row.want.pitch0 = pitch0;
      directed_rows.push_back(row);
   endtask

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_frame_desc(format_type f, dim_type w, dim_type h,
                                  layout_type want);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - FORMAT_W - 2 * DIM_W){1'b0}}, h, w, f};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      layout_q.push_back(want);
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      layout_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = layout_type'(rsp_tdata);
         if (layout_q.size() == 0) begin
            $error("response word with nothing outstanding");
            mismatch_count++;
         end else begin
            want = layout_q.pop_front();
            check_field("total_bytes", 64'(want.total), 64'(got.total));
            check_field("plane1_offset", 64'(want.off1), 64'(got.off1));
            check_field("plane2_offset", 64'(want.off2), 64'(got.off2));
            check_field("plane3_offset", 64'(want.off3), 64'(got.off3));
            check_field("pitch0", 64'(want.pitch0), 64'(got.pitch0));
            check_field("pitch1", 64'(want.pitch1), 64'(got.pitch1));
            check_field("pitch2", 64'(want.pitch2), 64'(got.pitch2));
            check_field("pitch3", 64'(want.pitch3), 64'(got.pitch3));
         end
      end
   end

   // response side back-pressure
   initial begin : rsp_side
      int  mode, left, beat;
      bit  rdy;
      mode = 0;
      left = 0;
      beat = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 150);
         end
         left--;
         beat++;
         case (mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = (beat % 4) != 0;
            default: rdy = ($urandom_range(0, 3) == 0);
         endcase
         rsp_tready <= rdy;
      end
   end

   initial begin : stimulus
      format_type f;
      dim_type    w, h;
      layout_type want;
      int         burst_left, gap;

      // all-zero cases, alignment of tiny planes, pitch extremes
      add_row(FMT_NONE, 14'd16383, 14'd16383, 1'b1, 31'd0, 16'd0);
      add_row(5'd31, 14'd16383, 14'd16383, 1'b1, 31'd0, 16'd0);
      add_row(5'd17, 14'd100, 14'd100, 1'b1, 31'd0, 16'd0);
      add_row(FMT_I420, 14'd0, 14'd16383, 1'b1, 31'd0, 16'd0);
      add_row(FMT_RGBA, 14'd16383, 14'd0, 1'b1, 31'd0, 16'd65532);
      add_row(FMT_Y800, 14'd1, 14'd1, 1'b1, 31'd32, 16'd1);
      add_row(FMT_YUY2, 14'd16, 14'd1, 1'b1, 31'd32, 16'd32);
      for (int c = FMT_I420; c <= FMT_YUVA; c++)
         add_row(format_type'(c), 14'd16383, 14'd16383, 1'b0, 31'd0, 16'd0);
      add_row(FMT_I422, 14'd3, 14'd5, 1'b0, 31'd0, 16'd0);
      add_row(FMT_NV12, 14'd1, 14'd1, 1'b0, 31'd0, 16'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         want = directed_rows[i].literal ? directed_rows[i].want
              : compute_layout(directed_rows[i].fmt, directed_rows[i].width,
                               directed_rows[i].height);
         send_frame_desc(directed_rows[i].fmt, directed_rows[i].width,
                         directed_rows[i].height, want);
      end

      // let the pipe drain completely before the random part
      req_tvalid <= 1'b0;
      do @(posedge clock); while (layout_q.size() != 0);

      burst_left = 0;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 150) long_hold_req = 1'b1;
         if (i == 500) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (layout_q.size() != 0);
         end else if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 24);
         end
         if (burst_left != 0) burst_left--;
         f = pick_format();
         w = pick_dim();
         h = pick_dim();
         send_frame_desc(f, w, h, compute_layout(f, w, h));
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (layout_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && layout_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/vplc_pkg.sv
sv/video_plane_layout_calc_top.sv
verif/testbench.sv
